[hdl/tpc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants, codes and types of the trie insert / prefix count block.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;

    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = NODE_W + 1;
    localparam int IDX_W      = $clog2(ALPHABET_SIZE);
    localparam int SLOT_COUNT = NODE_COUNT * ALPHABET_SIZE;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [7:0]       CHAR_A  = 8'h61;
    localparam logic [7:0]       CHAR_Z  = 8'h7a;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_ABSENT   = 3'd1,
        ST_PREFIX   = 3'd2,
        ST_WORD     = 3'd3,
        ST_FULL     = 3'd4,
        ST_BADCHAR  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    // One slot per (parent node, letter). Each non-root node has exactly one
    // incoming link, so its pass count and word mark live in that slot.
    typedef struct packed {
        logic              mark;
        logic [CNT_W-1:0]  count;
        logic [NODE_W-1:0] link;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_res_req;

endpackage
`default_nettype wire

[hdl/tpc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_in_if / tpc_out_if
// Valid/ready channels for characters in and lookup results out.
// ----------------------------------------------------------------------------
interface tpc_in_if import tpc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] letter;
    logic       last_char;

    modport source (output valid, output opcode, output letter, output last_char,
                    input ready);
    modport sink   (input valid, input opcode, input letter, input last_char,
                    output ready);
endinterface

interface tpc_out_if import tpc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [CNT_W-1:0] occurrences;

    modport source (output valid, output status, output occurrences, input ready);
    modport sink   (input valid, input status, input occurrences, output ready);
endinterface
`default_nettype wire

[hdl/trie_insert_and_prefix_count.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trie_insert_and_prefix_count
// Lowercase-word trie with insert and prefix-count query, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one character per transaction: opcode (insert or query),
//   the raw byte and a last-of-string mark. Only the last character of a
//   string yields a transaction on o_out: status and pass count of the final
//   node (count is zero for absent, table full and bad character).
//   Each character is accepted in the idle state, which issues the read of
//   the slot (parent node, letter) in the slot memory for a valid letter;
//   for an insert, the lookup state that follows writes the updated link,
//   count and word mark back. No new character is taken until the lookup
//   ends; a last character's result then shows on o_out in the cycle after.
//   After reset the slot memory is swept to zero, one slot per cycle, over
//   all SLOT_COUNT (26624) slots; i_in.ready stays low during the sweep.
//   When the receiver stalls, a waiting result is held; the next character
//   is still accepted, and only a further last character waits in the
//   lookup cycle until the output register frees up.
// ----------------------------------------------------------------------------
module trie_insert_and_prefix_count import tpc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tpc_in_if.sink    i_in,
    tpc_out_if.source o_out
);

    t_ram_req ram_req;
    t_entry   rd_data;
    t_res_req res;
    logic     out_free;

    // walker: clearing sweep, lookup and read-modify-write sequencing
    tpc_walker u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_rd_data  (rd_data),
        .o_ram      (ram_req),
        .i_out_free (out_free),
        .o_res      (res)
    );

    // slot memory: child link plus the child's count and word mark
    tpc_node_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // result register toward the receiver
    tpc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    // a result is pushed only into a free output register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> out_free)
        else $error("result pushed into a full output register");

    // the accept cycle never writes the slot memory
    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !ram_req.we)
        else $error("slot memory written while taking a character");

    // a character is followed by its lookup cycle, not by another accept
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("character accepted during a lookup");

    // reads are issued only for an accepted character
    a_read_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.re |-> (i_in.valid && i_in.ready))
        else $error("slot read without an accepted character");

endmodule
`default_nettype wire

[hdl/tpc_node_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_node_ram
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tpc_node_ram import tpc_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_ram_req i_req,
    output t_entry        o_rd_data
);

    t_entry r_mem [SLOT_COUNT];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[hdl/tpc_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_out_reg
// Result holding register between the walker and the output channel.
// ----------------------------------------------------------------------------
module tpc_out_reg import tpc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_res_req i_res,
    output logic          o_free,
    tpc_out_if.source     o_out
);

    logic             r_valid;
    logic [2:0]       r_status;
    logic [CNT_W-1:0] r_count;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.valid) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload loads only on a push
    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_status <= i_res.status;
            r_count  <= i_res.count;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_status;
    assign o_out.occurrences = r_count;

endmodule
`default_nettype wire

[hdl/tpc_walker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_walker
// Clearing sweep, per-character slot lookup and read-modify-write of the trie.
// ----------------------------------------------------------------------------
module tpc_walker import tpc_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tpc_in_if.sink      i_in,
    input  wire t_entry i_rd_data,
    output t_ram_req    o_ram,
    input  wire logic   i_out_free,
    output t_res_req    o_res
);

    t_state r_state, n_state;

    logic [SLOT_W-1:0] r_clr_addr;
    logic [NODE_W-1:0] r_cur;
    logic [FREE_W-1:0] r_free;
    logic              r_fail_hit;
    t_status           r_fail_code;

    // captured transaction
    t_opcode           r_op;
    logic              r_last;
    logic              r_chr_ok;
    logic [SLOT_W-1:0] r_slot;

    logic              clr_done;
    logic [7:0]        diff;
    logic              chr_ok;
    logic [IDX_W-1:0]  idx;
    logic [SLOT_W-1:0] slot;
    logic              accept;
    logic              leave;

    logic              fail;
    t_status           fail_code;
    logic              alloc;
    t_entry            upd;
    logic              do_write;
    t_status           res_status;
    logic [CNT_W-1:0]  res_count;

    assign clr_done = (r_clr_addr == SLOT_W'(SLOT_COUNT - 1));

    // slot address of the incoming character
    always_comb begin
        diff   = i_in.letter - CHAR_A;
        chr_ok = (i_in.letter >= CHAR_A) && (i_in.letter <= CHAR_Z)
                 && ({1'b0, diff} < 9'(ALPHABET_SIZE));
        idx    = diff[IDX_W-1:0];
        slot   = SLOT_W'(32'(r_cur) * 32'(ALPHABET_SIZE)) + SLOT_W'(idx);
    end

    // evaluate the slot just read
    always_comb begin
        fail      = 1'b0;
        fail_code = ST_ABSENT;
        alloc     = 1'b0;
        if (!r_fail_hit) begin
            if (!r_chr_ok) begin
                fail      = 1'b1;
                fail_code = (r_op == OP_QUERY) ? ST_ABSENT : ST_BADCHAR;
            end else if (i_rd_data.link == '0) begin
                if (r_op == OP_QUERY) begin
                    fail      = 1'b1;
                    fail_code = ST_ABSENT;
                end else if (r_free >= FREE_W'(NODE_COUNT)) begin
                    fail      = 1'b1;
                    fail_code = ST_FULL;
                end else begin
                    alloc = 1'b1;
                end
            end
        end

        upd.link  = alloc ? r_free[NODE_W-1:0] : i_rd_data.link;
        upd.count = (r_op == OP_INSERT && i_rd_data.count != CNT_MAX)
                    ? i_rd_data.count + CNT_W'(1) : i_rd_data.count;
        upd.mark  = i_rd_data.mark | ((r_op == OP_INSERT) & r_last);

        if (r_fail_hit) begin
            res_status = r_fail_code;
        end else if (fail) begin
            res_status = fail_code;
        end else if (r_op == OP_INSERT) begin
            res_status = ST_INSERTED;
        end else begin
            res_status = i_rd_data.mark ? ST_WORD : ST_PREFIX;
        end
        res_count = (r_fail_hit || fail) ? '0 : upd.count;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in.valid) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                if (!r_last || i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready  = 1'b0;
        accept      = 1'b0;
        leave       = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_slot;
        o_ram.wdata = upd;
        o_ram.re    = 1'b0;
        o_ram.raddr = slot;
        o_res.valid = 1'b0;
        do_write    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_clr_addr;
                o_ram.wdata = '0;
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                accept     = i_in.valid;
                o_ram.re   = i_in.valid && !r_fail_hit && chr_ok;
            end
            S_LOOKUP: begin
                leave       = !r_last || i_out_free;
                do_write    = leave && !r_fail_hit && !fail && (r_op == OP_INSERT);
                o_ram.we    = do_write;
                o_res.valid = leave && r_last;
            end
            default: begin
                o_ram.we = 1'b0;
            end
        endcase
        o_res.status = res_status;
        o_res.count  = res_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_cur       <= '0;
            r_free      <= FREE_W'(1);
            r_fail_hit  <= 1'b0;
            r_fail_code <= ST_ABSENT;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR && !clr_done) begin
                r_clr_addr <= r_clr_addr + SLOT_W'(1);
            end
            if (leave) begin
                if (do_write && alloc) begin
                    r_free <= r_free + FREE_W'(1);
                end
                if (r_last) begin
                    r_cur      <= '0;
                    r_fail_hit <= 1'b0;
                end else begin
                    if (!r_fail_hit && !fail) begin
                        r_cur <= upd.link;
                    end
                    if (fail) begin
                        r_fail_hit  <= 1'b1;
                        r_fail_code <= fail_code;
                    end
                end
            end
        end
    end

    // hold the transaction while the lookup is in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_opcode'(i_in.opcode);
            r_last   <= i_in.last_char;
            r_chr_ok <= chr_ok;
            r_slot   <= slot;
        end
    end

endmodule
`default_nettype wire
